>>> sv/dq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types and constants for the circular deque controller and datapath.
// ----------------------------------------------------------------------------
package dq_pkg;

    localparam int CAPACITY_DEF = 1024;
    localparam int DATA_W       = 32;

    // value returned by a pop from an empty deque (-256)
    localparam logic [DATA_W-1:0] UNDERFLOW_VALUE = 32'hFFFF_FF00;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RESP
    } state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;     // capture the request
        logic exec;     // carry out the captured request
    } ctl_t;

endpackage : dq_pkg
`default_nettype wire

>>> sv/dq_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_ctrl
// Sequencer: capture a request, execute it, present the result for one cycle.
// ----------------------------------------------------------------------------
module dq_ctrl
    import dq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic start,
    output logic      busy,
    output logic      done,
    output ctl_t      ctl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        busy       = 1'b0;
        done       = 1'b0;
        ctl        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                busy       = 1'b1;
                ctl.exec   = 1'b1;
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                // result on the ports; a new request may be taken alongside
                done = 1'b1;
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = ST_EXEC;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule : dq_ctrl
`default_nettype wire

>>> sv/dq_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// dq_datapath
// Indices, empty flag, element store and result registers of the deque.
// ----------------------------------------------------------------------------
module dq_datapath
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctl_t               ctl,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] push_value,
    output logic signed [31:0]      pop_value,
    output logic                    overflow,
    output logic                    underflow,
    output logic                    now_empty
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(CAPACITY - 1);

    logic [DATA_W-1:0] mem [CAPACITY];

    cmd_t              cmd_reg;
    logic [DATA_W-1:0] value_reg;

    logic [IDX_W-1:0]  front_reg, front_next;
    logic [IDX_W-1:0]  back_reg,  back_next;
    logic              empty_reg, empty_next;

    logic              ovf_reg, ovf_next;
    logic              unf_reg, unf_next;
    logic              popok_reg, popok_next;
    logic [DATA_W-1:0] rd_reg;

    logic              mem_we;
    logic              mem_re;
    logic [IDX_W-1:0]  mem_addr;

    logic              full;
    logic [IDX_W-1:0]  front_prev, front_succ;
    logic [IDX_W-1:0]  back_prev,  back_succ;

    assign front_succ = (front_reg == LAST_SLOT) ? '0 : front_reg + 1'b1;
    assign front_prev = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;
    assign back_succ  = (back_reg == LAST_SLOT) ? '0 : back_reg + 1'b1;
    assign back_prev  = (back_reg == '0) ? LAST_SLOT : back_reg - 1'b1;
    assign full       = !empty_reg && (back_succ == front_reg);

    always_comb
    begin
        front_next = front_reg;
        back_next  = back_reg;
        empty_next = empty_reg;
        ovf_next   = 1'b0;
        unf_next   = 1'b0;
        popok_next = 1'b0;
        mem_we     = 1'b0;
        mem_re     = 1'b0;
        mem_addr   = front_reg;
        unique case (cmd_reg)
            CMD_PUSH_FRONT, CMD_PUSH_BACK:
            begin
                if (full)
                begin
                    ovf_next = 1'b1;
                end
                else if (empty_reg)
                begin
                    // first element: last slot from the front, slot 0 from the back
                    mem_addr   = (cmd_reg == CMD_PUSH_FRONT) ? LAST_SLOT : '0;
                    front_next = mem_addr;
                    back_next  = mem_addr;
                    empty_next = 1'b0;
                    mem_we     = 1'b1;
                end
                else if (cmd_reg == CMD_PUSH_FRONT)
                begin
                    mem_addr   = front_prev;
                    front_next = front_prev;
                    mem_we     = 1'b1;
                end
                else
                begin
                    mem_addr  = back_succ;
                    back_next = back_succ;
                    mem_we    = 1'b1;
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK:
            begin
                if (empty_reg)
                begin
                    unf_next = 1'b1;
                end
                else
                begin
                    popok_next = 1'b1;
                    mem_re     = 1'b1;
                    mem_addr   = (cmd_reg == CMD_POP_FRONT) ? front_reg : back_reg;
                    if (front_reg == back_reg)
                    begin
                        empty_next = 1'b1;
                    end
                    else if (cmd_reg == CMD_POP_FRONT)
                    begin
                        front_next = front_succ;
                    end
                    else
                    begin
                        back_next = back_prev;
                    end
                end
            end
            default:
            begin
                mem_addr = front_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            back_reg  <= '0;
            empty_reg <= 1'b1;
            ovf_reg   <= 1'b0;
            unf_reg   <= 1'b0;
            popok_reg <= 1'b0;
        end
        else if (ctl.exec)
        begin
            front_reg <= front_next;
            back_reg  <= back_next;
            empty_reg <= empty_next;
            ovf_reg   <= ovf_next;
            unf_reg   <= unf_next;
            popok_reg <= popok_next;
        end
    end

    // request capture; payload only
    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            cmd_reg   <= cmd_t'(command);
            value_reg <= push_value;
        end
    end

    // element store, single port, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.exec && mem_we)
        begin
            mem[mem_addr] <= value_reg;
        end
        if (ctl.exec && mem_re)
        begin
            rd_reg <= mem[mem_addr];
        end
    end

    assign pop_value = popok_reg ? signed'(rd_reg)
                     : unf_reg   ? signed'(UNDERFLOW_VALUE)
                     : '0;
    assign overflow  = ovf_reg;
    assign underflow = unf_reg;
    assign now_empty = empty_reg;

endmodule : dq_datapath
`default_nettype wire

>>> sv/circular_deque.sv
`default_nettype none
// ----------------------------------------------------------------------------
// circular_deque
// Double-ended queue of CAPACITY 32-bit elements in a circular store.
// ----------------------------------------------------------------------------
// Sequence: a request accepted on start is captured, then carried out in the
//   execute state, and its result is strobed on done in the result state.
// A new request can be accepted in the result state, not in the execute state;
//   busy is high only there, for the single-port store access and index update.
// Results cannot be stalled; done marks each one for exactly one cycle.
// Reset (rst_n, asynchronous, low): deque empty, both indices zero, no result
//   pending. The element store is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module circular_deque
    import dq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [1:0]         command,
    input  wire logic signed [31:0] push_value,
    output logic                    done,
    output logic signed [31:0]      pop_value,
    output logic                    overflow,
    output logic                    underflow,
    output logic                    now_empty
);

    // commands from the sequencer into the datapath
    ctl_t ctl;

    // sequencer: idle -> execute -> result, a new request may join the result cycle
    dq_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .ctl   (ctl)
    );

    // indices, empty flag, store and result registers
    dq_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .command    (command),
        .push_value (push_value),
        .pop_value  (pop_value),
        .overflow   (overflow),
        .underflow  (underflow),
        .now_empty  (now_empty)
    );

`ifndef SYNTHESIS
    // every executed request is followed by exactly one result strobe
    a_exec_then_done : assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> done)
        else $error("execute cycle not followed by a result");

    // result strobes never come in consecutive cycles
    a_done_spacing : assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobes in consecutive cycles");

    // an underflowing pop leaves the deque empty
    a_unf_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (done && underflow) |-> now_empty)
        else $error("underflow reported with non-empty deque");

    // a dropped push means the deque was full, hence not empty
    a_ovf_not_empty : assert property (@(posedge clk) disable iff (!rst_n)
        (done && overflow) |-> (!now_empty && !underflow))
        else $error("overflow reported with empty deque or underflow");
`endif

endmodule : circular_deque
`default_nettype wire
